[rtl/ui_nav_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ui_nav_pkg
// Mode, event and register codes shared by the menu navigation machine.
// ----------------------------------------------------------------------------
package ui_nav_pkg;

   localparam int EVENT_WIDTH    = 5;
   localparam int TIME_WIDTH     = 32;
   localparam int MODE_WIDTH     = 4;
   localparam int MENU_WIDTH     = 2;
   localparam int CURSOR_OUT_W   = 8;
   localparam int LIMIT_WIDTH    = 8;
   localparam int REQ_DATA_WIDTH = 40;
   localparam int RSP_DATA_WIDTH = 56;
   localparam int CSR_IDX_WIDTH  = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CONTACT_MAX = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LINK_MAX    = 1'd1;

   // event codes
   localparam logic [EVENT_WIDTH-1:0] EV_PAIR_LONG     = 5'd1;
   localparam logic [EVENT_WIDTH-1:0] EV_PAIR_OVERTIME = 5'd2;
   localparam logic [EVENT_WIDTH-1:0] EV_CARD_OVERTIME = 5'd3;
   localparam logic [EVENT_WIDTH-1:0] EV_LEFT          = 5'd4;
   localparam logic [EVENT_WIDTH-1:0] EV_RIGHT         = 5'd6;
   localparam logic [EVENT_WIDTH-1:0] EV_UP            = 5'd8;
   localparam logic [EVENT_WIDTH-1:0] EV_DOWN          = 5'd10;
   localparam logic [EVENT_WIDTH-1:0] EV_ACOM_OK       = 5'd12;
   localparam logic [EVENT_WIDTH-1:0] EV_ACOM_FAIL     = 5'd13;
   localparam logic [EVENT_WIDTH-1:0] EV_BLE_START     = 5'd14;
   localparam logic [EVENT_WIDTH-1:0] EV_BLE_OK        = 5'd15;
   localparam logic [EVENT_WIDTH-1:0] EV_BLE_FAIL      = 5'd16;
   localparam logic [EVENT_WIDTH-1:0] EV_SETTINGS      = 5'd17;
   localparam logic [EVENT_WIDTH-1:0] EV_BATLOW        = 5'd18;
   localparam logic [EVENT_WIDTH-1:0] EV_SHUTDOWN      = 5'd19;

   // menu entries
   localparam logic [MENU_WIDTH-1:0] CHOICE_SELF     = 2'd0;
   localparam logic [MENU_WIDTH-1:0] CHOICE_CONTACTS = 2'd1;
   localparam logic [MENU_WIDTH-1:0] CHOICE_SETUP    = 2'd2;

   // external mode numbers
   localparam logic [MODE_WIDTH-1:0] CODE_IDLE     = 4'd0;
   localparam logic [MODE_WIDTH-1:0] CODE_PAIRING  = 4'd1;
   localparam logic [MODE_WIDTH-1:0] CODE_CARD     = 4'd2;
   localparam logic [MODE_WIDTH-1:0] CODE_MENU     = 4'd3;
   localparam logic [MODE_WIDTH-1:0] CODE_CLIST    = 4'd4;
   localparam logic [MODE_WIDTH-1:0] CODE_AVATAR   = 4'd5;
   localparam logic [MODE_WIDTH-1:0] CODE_LINKS    = 4'd6;
   localparam logic [MODE_WIDTH-1:0] CODE_QR       = 4'd7;
   localparam logic [MODE_WIDTH-1:0] CODE_SETTINGS = 4'd8;
   localparam logic [MODE_WIDTH-1:0] CODE_STANDBY  = 4'd9;
   localparam logic [MODE_WIDTH-1:0] CODE_LOWBAT   = 4'd10;
   localparam logic [MODE_WIDTH-1:0] CODE_BLECONN  = 4'd11;
   localparam logic [MODE_WIDTH-1:0] CODE_BLEXFER  = 4'd12;

   typedef enum logic [12:0] {
      MODE_IDLE     = 13'b0_0000_0000_0001,
      MODE_PAIRING  = 13'b0_0000_0000_0010,
      MODE_CARD     = 13'b0_0000_0000_0100,
      MODE_MENU     = 13'b0_0000_0000_1000,
      MODE_CLIST    = 13'b0_0000_0001_0000,
      MODE_AVATAR   = 13'b0_0000_0010_0000,
      MODE_LINKS    = 13'b0_0000_0100_0000,
      MODE_QR       = 13'b0_0000_1000_0000,
      MODE_SETTINGS = 13'b0_0001_0000_0000,
      MODE_STANDBY  = 13'b0_0010_0000_0000,
      MODE_LOWBAT   = 13'b0_0100_0000_0000,
      MODE_BLECONN  = 13'b0_1000_0000_0000,
      MODE_BLEXFER  = 13'b1_0000_0000_0000
   } mode_type;

   function automatic logic [MODE_WIDTH-1:0] mode_code(input mode_type m);
      logic [MODE_WIDTH-1:0] code;
      case (m)
         MODE_IDLE:     code = CODE_IDLE;
         MODE_PAIRING:  code = CODE_PAIRING;
         MODE_CARD:     code = CODE_CARD;
         MODE_MENU:     code = CODE_MENU;
         MODE_CLIST:    code = CODE_CLIST;
         MODE_AVATAR:   code = CODE_AVATAR;
         MODE_LINKS:    code = CODE_LINKS;
         MODE_QR:       code = CODE_QR;
         MODE_SETTINGS: code = CODE_SETTINGS;
         MODE_STANDBY:  code = CODE_STANDBY;
         MODE_LOWBAT:   code = CODE_LOWBAT;
         MODE_BLECONN:  code = CODE_BLECONN;
         MODE_BLEXFER:  code = CODE_BLEXFER;
         default:       code = CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

[rtl/ui_menu_navigation_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ui_menu_navigation_fsm
// Event-driven device mode machine with menu and list cursors.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  req_     | in        | event_code, now_ms
//  rsp_     | out       | mode, menu_choice, contact_cursor, link_cursor,
//           |           | viewing_self, mode_entered_at
//  csr_     | in        | contact_index_max, link_index_max writes
//
//  One item per cycle when rsp_ does not stall; each item passes the input
//  register and then sits in the result register until taken.
//  The input register takes a new item while a result waits downstream.
//  Synchronous reset returns to idle with both cursor bounds at 255.
//  A stalled rsp_ side holds the result and fills the input register, then
//  req_tready drops.
// ----------------------------------------------------------------------------
module ui_menu_navigation_fsm #(
   parameter int CURSOR_WIDTH = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // tdata: event_code[4:0], now_ms[36:5], zero fill
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [ui_nav_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // tdata: mode[3:0], menu_choice[5:4], contact_cursor[13:6],
   //        link_cursor[21:14], viewing_self[22], mode_entered_at[54:23], zero
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [ui_nav_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                   csr_wr_en,
   input  logic [ui_nav_pkg::CSR_IDX_WIDTH-1:0]   csr_wr_index,
   input  logic [ui_nav_pkg::LIMIT_WIDTH-1:0]     csr_wr_data
);
   import ui_nav_pkg::*;

   localparam int CW = CURSOR_WIDTH;
   // compare width wide enough for both the cursor and the 8-bit bound
   localparam int LW = (CW > LIMIT_WIDTH) ? CW : LIMIT_WIDTH;
   localparam logic [LW-1:0] CURSOR_CAP = LW'((32'd1 << CW) - 32'd1);

   logic [LIMIT_WIDTH-1:0]  contact_max_ff, link_max_ff;

   logic                    in_valid_ff;
   logic [EVENT_WIDTH-1:0]  in_event_ff;
   logic [TIME_WIDTH-1:0]   in_now_ff;

   mode_type                mode_ff, mode_in;
   mode_type                pair_ret_ff, pair_ret_in;
   mode_type                prof_ret_ff, prof_ret_in;
   logic [MENU_WIDTH-1:0]   menu_ff, menu_in;
   logic [CW-1:0]           contact_ff, contact_in;
   logic [CW-1:0]           link_ff, link_in;
   logic [TIME_WIDTH-1:0]   entry_ff, entry_in;

   logic                    out_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] out_data_ff;

   logic                    advance;
   logic                    stamp;
   logic [LW-1:0]           contact_ext, link_ext, contact_lim, link_lim;
   logic [LW-1:0]           contact_next_ext, link_next_ext;
   logic [LW-1:0]           contact_max_ext, link_max_ext;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // saturation limits: min(bound, 2^CW - 1)
   assign contact_max_ext = LW'(contact_max_ff);
   assign link_max_ext    = LW'(link_max_ff);
   assign contact_lim = (contact_max_ext < CURSOR_CAP) ? contact_max_ext : CURSOR_CAP;
   assign link_lim    = (link_max_ext < CURSOR_CAP) ? link_max_ext : CURSOR_CAP;
   assign contact_ext = LW'(contact_ff);
   assign link_ext    = LW'(link_ff);

   always_comb begin
      mode_in     = mode_ff;
      pair_ret_in = pair_ret_ff;
      prof_ret_in = prof_ret_ff;
      menu_in     = menu_ff;
      contact_in  = contact_ff;
      link_in     = link_ff;
      stamp       = 1'b0;
      case (mode_ff)
         MODE_IDLE: begin
            if (in_event_ff == EV_PAIR_LONG) begin
               pair_ret_in = MODE_IDLE;
               mode_in     = MODE_PAIRING;
               stamp       = 1'b1;
            end else if (in_event_ff == EV_RIGHT) begin
               mode_in = MODE_MENU;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_SETTINGS) begin
               mode_in = MODE_SETTINGS;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_SHUTDOWN) begin
               mode_in = MODE_STANDBY;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_BATLOW) begin
               mode_in = MODE_LOWBAT;
            end
         end
         MODE_PAIRING: begin
            if (in_event_ff == EV_PAIR_LONG || in_event_ff == EV_PAIR_OVERTIME ||
                in_event_ff == EV_ACOM_FAIL) begin
               mode_in = pair_ret_ff;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_ACOM_OK) begin
               mode_in = MODE_BLECONN;
               stamp   = 1'b1;
            end
         end
         MODE_CARD: begin
            if (in_event_ff == EV_PAIR_LONG || in_event_ff == EV_CARD_OVERTIME) begin
               mode_in = MODE_IDLE;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_BATLOW) begin
               mode_in = MODE_LOWBAT;
            end
         end
         MODE_MENU: begin
            if (in_event_ff == EV_LEFT) begin
               mode_in = MODE_IDLE;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_UP) begin
               // wrap backward over the three entries
               case (menu_ff)
                  CHOICE_SELF:     menu_in = CHOICE_SETUP;
                  CHOICE_CONTACTS: menu_in = CHOICE_SELF;
                  CHOICE_SETUP:    menu_in = CHOICE_CONTACTS;
                  default:         menu_in = CHOICE_SETUP;
               endcase
            end else if (in_event_ff == EV_DOWN) begin
               case (menu_ff)
                  CHOICE_SELF:     menu_in = CHOICE_CONTACTS;
                  CHOICE_CONTACTS: menu_in = CHOICE_SETUP;
                  CHOICE_SETUP:    menu_in = CHOICE_SELF;
                  default:         menu_in = CHOICE_CONTACTS;
               endcase
            end else if (in_event_ff == EV_RIGHT) begin
               stamp = 1'b1;
               case (menu_ff)
                  CHOICE_SELF: begin
                     prof_ret_in = MODE_MENU;
                     mode_in     = MODE_AVATAR;
                  end
                  CHOICE_CONTACTS: mode_in = MODE_CLIST;
                  CHOICE_SETUP:    mode_in = MODE_SETTINGS;
                  default:         mode_in = mode_ff;
               endcase
            end else if (in_event_ff == EV_SHUTDOWN) begin
               mode_in = MODE_STANDBY;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_BATLOW) begin
               mode_in = MODE_LOWBAT;
            end
         end
         MODE_CLIST: begin
            if (in_event_ff == EV_LEFT) begin
               mode_in = MODE_MENU;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_UP) begin
               if (contact_ff != '0) contact_in = contact_ff - CW'(1);
            end else if (in_event_ff == EV_DOWN) begin
               if (contact_ext < contact_lim) contact_in = contact_ff + CW'(1);
            end else if (in_event_ff == EV_RIGHT) begin
               prof_ret_in = MODE_CLIST;
               mode_in     = MODE_AVATAR;
               stamp       = 1'b1;
            end else if (in_event_ff == EV_SHUTDOWN) begin
               mode_in = MODE_STANDBY;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_BATLOW) begin
               mode_in = MODE_LOWBAT;
            end
         end
         MODE_AVATAR: begin
            if (in_event_ff == EV_LEFT) begin
               mode_in = prof_ret_ff;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_RIGHT) begin
               mode_in = MODE_LINKS;
               link_in = '0;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_SHUTDOWN) begin
               mode_in = MODE_STANDBY;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_BATLOW) begin
               mode_in = MODE_LOWBAT;
            end
         end
         MODE_LINKS: begin
            if (in_event_ff == EV_LEFT) begin
               mode_in = MODE_AVATAR;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_UP) begin
               if (link_ff != '0) link_in = link_ff - CW'(1);
            end else if (in_event_ff == EV_DOWN) begin
               if (link_ext < link_lim) link_in = link_ff + CW'(1);
            end else if (in_event_ff == EV_RIGHT) begin
               mode_in = MODE_QR;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_SHUTDOWN) begin
               mode_in = MODE_STANDBY;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_BATLOW) begin
               mode_in = MODE_LOWBAT;
            end
         end
         MODE_QR: begin
            if (in_event_ff == EV_LEFT) begin
               mode_in = MODE_LINKS;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_SHUTDOWN) begin
               mode_in = MODE_STANDBY;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_BATLOW) begin
               mode_in = MODE_LOWBAT;
            end
         end
         MODE_SETTINGS: begin
            if (in_event_ff == EV_LEFT) begin
               mode_in = MODE_MENU;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_BATLOW) begin
               mode_in = MODE_LOWBAT;
            end
         end
         MODE_STANDBY: begin
            if (in_event_ff == EV_PAIR_LONG) begin
               mode_in = MODE_IDLE;
               stamp   = 1'b1;
            end
         end
         MODE_BLECONN: begin
            if (in_event_ff == EV_BLE_START) begin
               mode_in = MODE_BLEXFER;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_BLE_OK) begin
               mode_in = MODE_CARD;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_PAIR_LONG || in_event_ff == EV_BLE_FAIL) begin
               mode_in = pair_ret_ff;
               stamp   = 1'b1;
            end
         end
         MODE_BLEXFER: begin
            if (in_event_ff == EV_BLE_OK) begin
               mode_in = MODE_CARD;
               stamp   = 1'b1;
            end else if (in_event_ff == EV_PAIR_LONG || in_event_ff == EV_BLE_FAIL) begin
               mode_in = pair_ret_ff;
               stamp   = 1'b1;
            end
         end
         // low battery locks out every event
         default: begin
            mode_in = mode_ff;
         end
      endcase
      entry_in = stamp ? in_now_ff : entry_ff;
   end

   assign contact_next_ext = LW'(contact_in);
   assign link_next_ext    = LW'(link_in);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         contact_max_ff <= '1;
         link_max_ff    <= '1;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         mode_ff        <= MODE_IDLE;
         pair_ret_ff    <= MODE_IDLE;
         prof_ret_ff    <= MODE_MENU;
         menu_ff        <= CHOICE_SELF;
         contact_ff     <= '0;
         link_ff        <= '0;
         entry_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_wr_index)
               CSR_CONTACT_MAX: contact_max_ff <= csr_wr_data;
               CSR_LINK_MAX:    link_max_ff    <= csr_wr_data;
               default:         contact_max_ff <= contact_max_ff;
            endcase
         end
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            mode_ff     <= mode_in;
            pair_ret_ff <= pair_ret_in;
            prof_ret_ff <= prof_ret_in;
            menu_ff     <= menu_in;
            contact_ff  <= contact_in;
            link_ff     <= link_in;
            entry_ff    <= entry_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_event_ff <= req_tdata[EVENT_WIDTH-1:0];
         in_now_ff   <= req_tdata[EVENT_WIDTH +: TIME_WIDTH];
      end
      if (advance) begin
         out_data_ff <= {1'b0,
                         entry_in,
                         (prof_ret_in == MODE_MENU),
                         link_next_ext[CURSOR_OUT_W-1:0],
                         contact_next_ext[CURSOR_OUT_W-1:0],
                         menu_in,
                         mode_code(mode_in)};
      end
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the menu navigation machine. Event items stream in
// with random gaps, results are taken with random stalls, and each result is
// compared field by field with a cycle-free model of the mode machine. Runs
// go through several cursor bound settings and end in the low-battery lock.
// ----------------------------------------------------------------------------
module tb;
   import ui_nav_pkg::*;

   localparam int CURSOR_WIDTH = 8;

   typedef struct packed {
      logic [MODE_WIDTH-1:0]   mode;
      logic [MODE_WIDTH-1:0]   pair_ret;
      logic [MODE_WIDTH-1:0]   prof_ret;
      logic [MENU_WIDTH-1:0]   menu_pos;
      logic [CURSOR_WIDTH-1:0] contact_pos;
      logic [CURSOR_WIDTH-1:0] link_pos;
      logic [TIME_WIDTH-1:0]   entered;
   } nav_state_type;

   // same bit order as rsp_tdata, lowest field last
   typedef struct packed {
      logic [TIME_WIDTH-1:0]   entered;
      logic                    self_view;
      logic [CURSOR_OUT_W-1:0] link_pos;
      logic [CURSOR_OUT_W-1:0] contact_pos;
      logic [MENU_WIDTH-1:0]   menu_pos;
      logic [MODE_WIDTH-1:0]   mode;
   } nav_view_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]  now;
      logic [EVENT_WIDTH-1:0] code;
      logic [3:0]             gap;
   } event_item_type;

   localparam nav_state_type NAV_RESET = '{
      mode: CODE_IDLE, pair_ret: CODE_IDLE, prof_ret: CODE_MENU,
      menu_pos: '0, contact_pos: '0, link_pos: '0, entered: '0};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_wr_index = '0;
   logic [LIMIT_WIDTH-1:0]    csr_wr_data = '0;

   logic [LIMIT_WIDTH-1:0] contact_bound = 8'd255;
   logic [LIMIT_WIDTH-1:0] link_bound = 8'd255;
   logic                   send_idle = 1'b1;
   logic                   recv_idle = 1'b1;

   event_item_type pending_events[$];
   nav_view_type   expected_views[$];
   nav_state_type  nav_live = NAV_RESET;
   nav_state_type  nav_plan = NAV_RESET;
   int             hold_left = 0;
   int             stall_left = 0;
   int             fail_count = 0;
   int             items_accepted = 0;
   int             results_checked = 0;

   ui_menu_navigation_fsm #(.CURSOR_WIDTH(CURSOR_WIDTH)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_index(csr_wr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [CURSOR_WIDTH-1:0] cursor_step_down(
         logic [CURSOR_WIDTH-1:0] pos, logic [LIMIT_WIDTH-1:0] bound);
      logic [CURSOR_WIDTH-1:0] cap;
      logic [CURSOR_WIDTH-1:0] lim;
      cap = '1;
      lim = (bound < cap) ? bound : cap;
      return (pos < lim) ? pos + CURSOR_WIDTH'(1) : pos;
   endfunction

   // next mode-machine state after one event
   function automatic nav_state_type nav_next(nav_state_type s,
         logic [EVENT_WIDTH-1:0] ev,
         logic [TIME_WIDTH-1:0] now, logic [LIMIT_WIDTH-1:0] cmax,
         logic [LIMIT_WIDTH-1:0] lmax);
      nav_state_type n;
      logic stamp;
      n = s;
      stamp = 1'b0;
      case (s.mode)
         CODE_IDLE: begin
            if (ev == EV_PAIR_LONG) begin
               n.pair_ret = CODE_IDLE; n.mode = CODE_PAIRING; stamp = 1'b1;
            end else if (ev == EV_RIGHT) begin
               n.mode = CODE_MENU; stamp = 1'b1;
            end else if (ev == EV_SETTINGS) begin
               n.mode = CODE_SETTINGS; stamp = 1'b1;
            end else if (ev == EV_SHUTDOWN) begin
               n.mode = CODE_STANDBY; stamp = 1'b1;
            end else if (ev == EV_BATLOW) begin
               n.mode = CODE_LOWBAT;
            end
         end
         CODE_PAIRING: begin
            if (ev == EV_PAIR_LONG || ev == EV_PAIR_OVERTIME || ev == EV_ACOM_FAIL) begin
               n.mode = s.pair_ret; stamp = 1'b1;
            end else if (ev == EV_ACOM_OK) begin
               n.mode = CODE_BLECONN; stamp = 1'b1;
            end
         end
         CODE_CARD: begin
            if (ev == EV_PAIR_LONG || ev == EV_CARD_OVERTIME) begin
               n.mode = CODE_IDLE; stamp = 1'b1;
            end else if (ev == EV_BATLOW) begin
               n.mode = CODE_LOWBAT;
            end
         end
         CODE_MENU: begin
            if (ev == EV_LEFT) begin
               n.mode = CODE_IDLE; stamp = 1'b1;
            end else if (ev == EV_UP) begin
               n.menu_pos = MENU_WIDTH'((int'(s.menu_pos) + 2) % 3);
            end else if (ev == EV_DOWN) begin
               n.menu_pos = MENU_WIDTH'((int'(s.menu_pos) + 1) % 3);
            end else if (ev == EV_RIGHT) begin
               if (s.menu_pos == CHOICE_SELF) begin
                  n.prof_ret = CODE_MENU; n.mode = CODE_AVATAR;
               end else if (s.menu_pos == CHOICE_CONTACTS) begin
                  n.mode = CODE_CLIST;
               end else if (s.menu_pos == CHOICE_SETUP) begin
                  n.mode = CODE_SETTINGS;
               end
               stamp = 1'b1;
            end else if (ev == EV_SHUTDOWN) begin
               n.mode = CODE_STANDBY; stamp = 1'b1;
            end else if (ev == EV_BATLOW) begin
               n.mode = CODE_LOWBAT;
            end
         end
         CODE_CLIST: begin
            if (ev == EV_LEFT) begin
               n.mode = CODE_MENU; stamp = 1'b1;
            end else if (ev == EV_UP) begin
               n.contact_pos = (s.contact_pos != 0) ? s.contact_pos - CURSOR_WIDTH'(1)
                                                    : s.contact_pos;
            end else if (ev == EV_DOWN) begin
               n.contact_pos = cursor_step_down(s.contact_pos, cmax);
            end else if (ev == EV_RIGHT) begin
               n.prof_ret = CODE_CLIST; n.mode = CODE_AVATAR; stamp = 1'b1;
            end else if (ev == EV_SHUTDOWN) begin
               n.mode = CODE_STANDBY; stamp = 1'b1;
            end else if (ev == EV_BATLOW) begin
               n.mode = CODE_LOWBAT;
            end
         end
         CODE_AVATAR: begin
            if (ev == EV_LEFT) begin
               n.mode = s.prof_ret; stamp = 1'b1;
            end else if (ev == EV_RIGHT) begin
               n.mode = CODE_LINKS; n.link_pos = '0; stamp = 1'b1;
            end else if (ev == EV_SHUTDOWN) begin
               n.mode = CODE_STANDBY; stamp = 1'b1;
            end else if (ev == EV_BATLOW) begin
               n.mode = CODE_LOWBAT;
            end
         end
         CODE_LINKS: begin
            if (ev == EV_LEFT) begin
               n.mode = CODE_AVATAR; stamp = 1'b1;
            end else if (ev == EV_UP) begin
               n.link_pos = (s.link_pos != 0) ? s.link_pos - CURSOR_WIDTH'(1) : s.link_pos;
            end else if (ev == EV_DOWN) begin
               n.link_pos = cursor_step_down(s.link_pos, lmax);
            end else if (ev == EV_RIGHT) begin
               n.mode = CODE_QR; stamp = 1'b1;
            end else if (ev == EV_SHUTDOWN) begin
               n.mode = CODE_STANDBY; stamp = 1'b1;
            end else if (ev == EV_BATLOW) begin
               n.mode = CODE_LOWBAT;
            end
         end
         CODE_QR: begin
            if (ev == EV_LEFT) begin
               n.mode = CODE_LINKS; stamp = 1'b1;
            end else if (ev == EV_SHUTDOWN) begin
               n.mode = CODE_STANDBY; stamp = 1'b1;
            end else if (ev == EV_BATLOW) begin
               n.mode = CODE_LOWBAT;
            end
         end
         CODE_SETTINGS: begin
            if (ev == EV_LEFT) begin
               n.mode = CODE_MENU; stamp = 1'b1;
            end else if (ev == EV_BATLOW) begin
               n.mode = CODE_LOWBAT;
            end
         end
         CODE_STANDBY: begin
            if (ev == EV_PAIR_LONG) begin
               n.mode = CODE_IDLE; stamp = 1'b1;
            end
         end
         CODE_BLECONN: begin
            if (ev == EV_BLE_START) begin
               n.mode = CODE_BLEXFER; stamp = 1'b1;
            end else if (ev == EV_BLE_OK) begin
               n.mode = CODE_CARD; stamp = 1'b1;
            end else if (ev == EV_PAIR_LONG || ev == EV_BLE_FAIL) begin
               n.mode = s.pair_ret; stamp = 1'b1;
            end
         end
         CODE_BLEXFER: begin
            if (ev == EV_BLE_OK) begin
               n.mode = CODE_CARD; stamp = 1'b1;
            end else if (ev == EV_PAIR_LONG || ev == EV_BLE_FAIL) begin
               n.mode = s.pair_ret; stamp = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (stamp)
         n.entered = now;
      return n;
   endfunction

   function automatic logic battery_drop_applies(logic [MODE_WIDTH-1:0] mode);
      return mode == CODE_IDLE || mode == CODE_CARD || mode == CODE_MENU ||
             mode == CODE_CLIST || mode == CODE_AVATAR || mode == CODE_LINKS ||
             mode == CODE_QR || mode == CODE_SETTINGS;
   endfunction

   // mostly events that move the current mode, some noise of any code
   function automatic logic [EVENT_WIDTH-1:0] pick_event(nav_state_type s);
      logic [EVENT_WIDTH-1:0] opts[$];
      logic [EVENT_WIDTH-1:0] code;
      if ($urandom_range(0, 99) < 12) begin
         code = EVENT_WIDTH'($urandom_range(0, 31));
         // a low-battery hit here would freeze the machine for the rest of the run
         if (code == EV_BATLOW && battery_drop_applies(s.mode))
            code = EVENT_WIDTH'($urandom_range(20, 31));
         return code;
      end
      case (s.mode)
         CODE_IDLE:     opts = '{EV_PAIR_LONG, EV_RIGHT, EV_RIGHT, EV_RIGHT, EV_SETTINGS,
                                 EV_SHUTDOWN};
         CODE_PAIRING:  opts = '{EV_ACOM_OK, EV_ACOM_OK, EV_PAIR_LONG, EV_PAIR_OVERTIME,
                                 EV_ACOM_FAIL};
         CODE_CARD:     opts = '{EV_PAIR_LONG, EV_CARD_OVERTIME};
         CODE_MENU:     opts = '{EV_LEFT, EV_UP, EV_DOWN, EV_DOWN, EV_RIGHT, EV_RIGHT,
                                 EV_RIGHT, EV_SHUTDOWN};
         CODE_CLIST:    opts = '{EV_LEFT, EV_UP, EV_DOWN, EV_RIGHT, EV_RIGHT, EV_SHUTDOWN};
         CODE_AVATAR:   opts = '{EV_LEFT, EV_LEFT, EV_RIGHT, EV_RIGHT, EV_SHUTDOWN};
         CODE_LINKS:    opts = '{EV_LEFT, EV_UP, EV_DOWN, EV_RIGHT, EV_SHUTDOWN};
         CODE_QR:       opts = '{EV_LEFT, EV_LEFT, EV_SHUTDOWN};
         CODE_SETTINGS: opts = '{EV_LEFT};
         CODE_STANDBY:  opts = '{EV_PAIR_LONG};
         CODE_BLECONN:  opts = '{EV_BLE_START, EV_BLE_OK, EV_PAIR_LONG, EV_BLE_FAIL};
         CODE_BLEXFER:  opts = '{EV_BLE_OK, EV_PAIR_LONG, EV_BLE_FAIL};
         default:       opts = '{EVENT_WIDTH'($urandom_range(0, 31))};
      endcase
      return opts[$urandom_range(0, opts.size() - 1)];
   endfunction

   task automatic queue_event(logic [EVENT_WIDTH-1:0] code, logic [TIME_WIDTH-1:0] now);
      event_item_type it;
      it.code = code;
      it.now = now;
      it.gap = send_idle ? 4'($urandom_range(0, 14)) : 4'd0;
      pending_events.push_back(it);
      nav_plan = nav_next(nav_plan, code, now, contact_bound, link_bound);
   endtask

   // hold until every item is through and the pipeline has gone quiet
   task automatic drain_pipeline();
      @(negedge clock);
      while (pending_events.size() != 0 || req_tvalid || expected_views.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_bound(logic [CSR_IDX_WIDTH-1:0] idx, logic [LIMIT_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_index <= idx;
      csr_wr_data <= value;
      if (idx == CSR_CONTACT_MAX)
         contact_bound = value;
      else
         link_bound = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_phase(int target);
      int made;
      int run_len;
      logic [EVENT_WIDTH-1:0] code;
      made = 0;
      while (made < target) begin
         if ((nav_plan.mode == CODE_CLIST || nav_plan.mode == CODE_LINKS) &&
             $urandom_range(0, 5) == 0) begin
            // cursor runs, now and then long enough to hit the top bound
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(2, 30);
            code = ($urandom_range(0, 2) != 0) ? EV_DOWN : EV_UP;
            repeat (run_len) queue_event(code, $urandom);
            made += run_len;
         end else begin
            code = pick_event(nav_plan);
            queue_event(code, $urandom);
            if (code <= EV_SHUTDOWN)
               made++;
         end
      end
   endtask

   task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         fail_count++;
      end
   endtask

   // sender
   always @(posedge clock) begin : driver_proc
      event_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         hold_left <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            req_tvalid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            nxt = pending_events.pop_front();
            req_tdata <= {{(REQ_DATA_WIDTH - EVENT_WIDTH - TIME_WIDTH){1'b0}},
                          nxt.now, nxt.code};
            req_tvalid <= 1'b1;
            hold_left <= nxt.gap;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // predict on accepted items, then check accepted results
   always @(posedge clock) begin : monitor_proc
      nav_view_type want;
      nav_view_type got;
      int gap;
      if (reset) begin
         nav_live = NAV_RESET;
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            nav_live = nav_next(nav_live, req_tdata[EVENT_WIDTH-1:0],
                                req_tdata[EVENT_WIDTH +: TIME_WIDTH],
                                contact_bound, link_bound);
            want.mode = nav_live.mode;
            want.menu_pos = nav_live.menu_pos;
            want.contact_pos = nav_live.contact_pos[CURSOR_OUT_W-1:0];
            want.link_pos = nav_live.link_pos[CURSOR_OUT_W-1:0];
            want.self_view = (nav_live.prof_ret == CODE_MENU);
            want.entered = nav_live.entered;
            expected_views.push_back(want);
            items_accepted++;
         end
         gap = stall_left;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(nav_view_type)-1:0];
            if (expected_views.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h", $time, got);
               fail_count++;
            end else begin
               want = expected_views.pop_front();
               check_field("mode", 32'(want.mode), 32'(got.mode));
               check_field("menu_choice", 32'(want.menu_pos), 32'(got.menu_pos));
               check_field("contact_cursor", 32'(want.contact_pos), 32'(got.contact_pos));
               check_field("link_cursor", 32'(want.link_pos), 32'(got.link_pos));
               check_field("viewing_self", 32'(want.self_view), 32'(got.self_view));
               check_field("mode_entered_at", want.entered, got.entered);
               results_checked++;
            end
            if (recv_idle)
               gap = $urandom_range(0, 14);
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            stall_left <= gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            stall_left <= 0;
         end
      end
   end

   initial begin : stimulus_proc
      logic [LIMIT_WIDTH-1:0] contact_set[5];
      logic [LIMIT_WIDTH-1:0] link_set[5];
      logic [1:0] idle_set[5];
      contact_set = '{8'd0, 8'd3, 8'd255, 8'd40, 8'd1};
      link_set = '{8'd0, 8'd255, 8'd7, 8'd255, 8'd200};
      idle_set = '{2'b11, 2'b00, 2'b11, 2'b10, 2'b01};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk every mode but low battery, with field extremes and the contact cursor floor
      queue_event(5'd31, 32'hFFFF_FFFF);
      queue_event(5'd0, 32'h0000_0000);
      queue_event(EV_PAIR_LONG, 32'hFFFF_FFFF);
      queue_event(EV_BATLOW, 32'h0000_0010);
      queue_event(EV_ACOM_OK, 32'h0000_0020);
      queue_event(EV_BLE_START, 32'h8000_0000);
      queue_event(EV_BLE_OK, 32'h0000_0040);
      queue_event(EV_CARD_OVERTIME, 32'h7FFF_FFFF);
      queue_event(EV_RIGHT, 32'h0000_0001);
      queue_event(EV_UP, 32'h0000_0002);
      queue_event(EV_DOWN, 32'h0000_0003);
      queue_event(EV_DOWN, 32'h0000_0004);
      queue_event(EV_RIGHT, 32'hA5A5_A5A5);
      queue_event(EV_UP, 32'h0000_0005);
      queue_event(EV_DOWN, 32'h0000_0006);
      queue_event(EV_RIGHT, 32'h5A5A_5A5A);
      queue_event(EV_RIGHT, 32'h0000_0100);
      queue_event(EV_DOWN, 32'h0000_0101);
      queue_event(EV_RIGHT, 32'h0000_0102);
      queue_event(EV_LEFT, 32'h0000_0103);
      queue_event(EV_LEFT, 32'h0000_0104);
      queue_event(EV_LEFT, 32'h0000_0105);
      queue_event(EV_SHUTDOWN, 32'h0000_0106);
      queue_event(EV_PAIR_LONG, 32'h0000_0107);
      queue_event(EV_SETTINGS, 32'h0000_0108);
      drain_pipeline();

      for (int p = 0; p < 5; p++) begin
         write_bound(CSR_CONTACT_MAX, contact_set[p]);
         write_bound(CSR_LINK_MAX, link_set[p]);
         send_idle = idle_set[p][1];
         recv_idle = idle_set[p][0];
         @(negedge clock);
         random_phase(300);
         drain_pipeline();
      end

      // finish in the low-battery lock: every later event must be ignored
      send_idle = 1'b1;
      recv_idle = 1'b1;
      while (!battery_drop_applies(nav_plan.mode))
         queue_event(pick_event(nav_plan), $urandom);
      queue_event(EV_BATLOW, $urandom);
      repeat (16) queue_event(EVENT_WIDTH'($urandom_range(0, 31)), $urandom);
      drain_pipeline();

      if (expected_views.size() != 0) begin
         $display("%0t: %0d results missing, expected more, actual none", $time,
                  expected_views.size());
         fail_count++;
      end
      $display("Ran %0d events and checked %0d results over 6 cursor bound settings,",
               items_accepted, results_checked);
      $display("through every mode, ending locked in low battery.");
      if (fail_count == 0)
         $display("ui_menu_navigation_fsm verification clean");
      else
         $display("ui_menu_navigation_fsm verification failed");
      $finish;
   end

   initial begin : watchdog_proc
      #(20_000_000);
      $display("ui_menu_navigation_fsm verification failed");
      $finish;
   end

endmodule
